### src/rm2e_pkg.sv
// ----------------------------------------------------------------------------
// rm2e_pkg
// Shared types and constants for the rotation matrix to Euler angle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rm2e_pkg;

    // Width of the CORDIC x and y datapath after normalization.
    localparam int CORDIC_W      = 34;
    // Width of the normalization exponent.
    localparam int EXP_W         = 8;
    // Number of CORDIC iterations, one cell each.
    localparam int CORDIC_STAGES = 30;
    // Register stages of one vectoring unit: two normalization stages, the cells, a fix-up stage.
    localparam int VEC_LATENCY   = CORDIC_STAGES + 3;
    // Target magnitude position after normalization.
    localparam int NORM_POS      = 29;

    // Angles in 32-bit turns.
    localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
    localparam logic [31:0] TURN_QUARTER  = 32'h4000_0000;
    localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;

    // CORDIC gain, round(K * 2^30).
    localparam logic [31:0] KGAIN_Q30 = 32'd1768195363;

    // atan(2^-i) in turns.
    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STAGES-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    // Side information that travels with a vector through the cells.
    typedef struct packed {
        logic                    xneg;
        logic                    xzero;
        logic                    yzero;
        logic                    ypos;
        logic                    mzero;
        logic signed [EXP_W-1:0] expo;
    } t_flags;

endpackage

`default_nettype wire

### src/rm2e_delay.sv
// ----------------------------------------------------------------------------
// rm2e_delay
// Shift line that carries side data alongside the CORDIC pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module rm2e_delay #(
    parameter int W     = 32,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_data,
    output logic      [W-1:0] o_data
);

    logic [W-1:0] r_taps [0:DEPTH-1];

    // Each tap moves one place whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_taps[0] <= i_data;
            for (int k = 1; k < DEPTH; k++) begin
                r_taps[k] <= r_taps[k-1];
            end
        end
    end

    assign o_data = r_taps[DEPTH-1];

endmodule

`default_nettype wire

### src/rm2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// rm2e_cordic_cell
// One vectoring CORDIC iteration with its output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rm2e_cordic_cell #(
    parameter int CW    = 34,
    parameter int STAGE = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic signed [CW-1:0]   i_x,
    input  wire logic signed [CW-1:0]   i_y,
    input  wire logic        [31:0]     i_z,
    input  wire rm2e_pkg::t_flags       i_flags,
    output logic                        o_valid,
    output logic signed [CW-1:0]        o_x,
    output logic signed [CW-1:0]        o_y,
    output logic        [31:0]          o_z,
    output rm2e_pkg::t_flags            o_flags
);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic        [31:0]   n_z;

    // Rotate toward the x axis; the sign of y picks the direction.
    always_comb begin
        dx = i_x >>> STAGE;
        dy = i_y >>> STAGE;
        if (i_y < 0) begin
            n_x = i_x - dy;
            n_y = i_y + dx;
            n_z = i_z - rm2e_pkg::ATAN_TURNS[STAGE];
        end else begin
            n_x = i_x + dy;
            n_y = i_y - dx;
            n_z = i_z + rm2e_pkg::ATAN_TURNS[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x     <= n_x;
            o_y     <= n_y;
            o_z     <= n_z;
            o_flags <= i_flags;
        end
    end

endmodule

`default_nettype wire

### src/rm2e_vec_atan.sv
// ----------------------------------------------------------------------------
// rm2e_vec_atan
// Pipelined atan2: normalization, a chain of CORDIC cells and exact-axis fix-up.
// ----------------------------------------------------------------------------
`default_nettype none

module rm2e_vec_atan #(
    parameter int IW = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_en,
    input  wire logic                                   i_valid,
    input  wire logic signed [IW-1:0]                   i_x,
    input  wire logic signed [IW-1:0]                   i_y,
    output logic                                        o_valid,
    output logic        [31:0]                          o_z,
    output logic signed [rm2e_pkg::CORDIC_W-1:0]        o_mag,
    output logic signed [rm2e_pkg::EXP_W-1:0]           o_expo
);

    localparam int CW = rm2e_pkg::CORDIC_W;
    localparam int NS = rm2e_pkg::CORDIC_STAGES;
    localparam int MW = IW + 1;
    localparam int PW = $clog2(IW + 31);
    localparam int EW = IW + rm2e_pkg::NORM_POS + 1;

    // ---------------- Stage one: magnitude and leading-one search ----------------
    logic        [MW-1:0] ax;
    logic        [MW-1:0] ay;
    logic        [MW-1:0] m;
    logic        [PW-1:0] n_p;

    always_comb begin
        ax  = i_x[IW-1] ? MW'(-{i_x[IW-1], i_x}) : MW'({1'b0, i_x});
        ay  = i_y[IW-1] ? MW'(-{i_y[IW-1], i_y}) : MW'({1'b0, i_y});
        m   = (ax > ay) ? ax : ay;
        n_p = '0;
        for (int k = 0; k < MW; k++) begin
            if (m[k]) begin
                n_p = PW'(k);
            end
        end
    end

    logic                 r_v1;
    logic signed [IW-1:0] r_x1;
    logic signed [IW-1:0] r_y1;
    logic        [PW-1:0] r_p1;
    rm2e_pkg::t_flags     r_f1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1       <= i_x;
            r_y1       <= i_y;
            r_p1       <= n_p;
            r_f1.xneg  <= i_x[IW-1];
            r_f1.xzero <= (i_x == '0);
            r_f1.yzero <= (i_y == '0);
            r_f1.ypos  <= !i_y[IW-1] && (i_y != '0);
            r_f1.mzero <= (i_x == '0) && (i_y == '0);
            r_f1.expo  <= '0;
        end
    end

    // ---------------- Stage two: scale to the working range, fold to x >= 0 ----------------
    logic signed [EW-1:0] xe;
    logic signed [EW-1:0] ye;
    logic signed [EW-1:0] xs;
    logic signed [EW-1:0] ys;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic        [31:0]   z0;
    rm2e_pkg::t_flags     f2;

    always_comb begin
        xe = EW'(r_x1);
        ye = EW'(r_y1);
        if (r_p1 > PW'(rm2e_pkg::NORM_POS)) begin
            xs = xe >>> (r_p1 - PW'(rm2e_pkg::NORM_POS));
            ys = ye >>> (r_p1 - PW'(rm2e_pkg::NORM_POS));
        end else begin
            xs = xe <<< (PW'(rm2e_pkg::NORM_POS) - r_p1);
            ys = ye <<< (PW'(rm2e_pkg::NORM_POS) - r_p1);
        end
        cx = xs[CW-1:0];
        cy = ys[CW-1:0];
        z0 = '0;
        if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            z0 = rm2e_pkg::TURN_HALF;
        end
        f2      = r_f1;
        f2.expo = rm2e_pkg::EXP_W'(rm2e_pkg::NORM_POS) - rm2e_pkg::EXP_W'(r_p1);
    end

    logic                 w_v [0:NS];
    logic signed [CW-1:0] w_x [0:NS];
    logic signed [CW-1:0] w_y [0:NS];
    logic        [31:0]   w_z [0:NS];
    rm2e_pkg::t_flags     w_f [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            w_v[0] <= 1'b0;
        end else if (i_en) begin
            w_v[0] <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            w_x[0] <= cx;
            w_y[0] <= cy;
            w_z[0] <= z0;
            w_f[0] <= f2;
        end
    end

    // ---------------- Chain of CORDIC cells ----------------
    for (genvar g = 0; g < NS; g++) begin : g_cell
        rm2e_cordic_cell #(
            .CW    (CW),
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_v[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_flags (w_f[g]),
            .o_valid (w_v[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_flags (w_f[g+1])
        );
    end

    // ---------------- Fix-up: exact axes and the zero vector ----------------
    logic [31:0] n_z;

    always_comb begin
        n_z = w_z[NS];
        if (w_f[NS].yzero) begin
            n_z = w_f[NS].xneg ? rm2e_pkg::TURN_HALF : '0;
        end else if (w_f[NS].xzero) begin
            n_z = w_f[NS].ypos ? rm2e_pkg::TURN_QUARTER : rm2e_pkg::TURN_3QUARTER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= w_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_z    <= n_z;
            o_mag  <= w_f[NS].mzero ? '0 : w_x[NS];
            o_expo <= w_f[NS].mzero ? '0 : w_f[NS].expo;
        end
    end

endmodule

`default_nettype wire

### src/rotation_matrix_to_euler_unit.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_unit
// Converts a rotation matrix to Z-Y-X Euler angles with CORDIC pipelines.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one matrix item (r00, r01, r02, r10, r11, r12, r20)
//   per handshake; the master channel returns one item of yaw, pitch and roll
//   as binary angles where pi equals 2^(ANGLE_BITS-1).
//   Yaw and roll run side by side through one chain of 30 CORDIC cells each;
//   pitch uses the yaw magnitude and runs through a second chain after that.
//   Throughput is one item per cycle while the skid register is free.
//   The whole pipeline moves on one enable. A two-entry output buffer (output
//   register plus skid register) sits at the end, so tready on the slave side
//   is a register: it drops only once the skid register holds an item while
//   the receiver stalls, and the pipeline then holds its contents.
//   Synchronous active-low reset clears every valid bit and the output buffer;
//   no item is in flight afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_euler_unit #(
    parameter int ELEMENT_BITS = 16,
    parameter int ANGLE_BITS   = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // Fields from bit 0 up: r00, r01, r02, r10, r11, r12, r20, zero fill.
    input  wire logic [((7*ELEMENT_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // Fields from bit 0 up: yaw_angle, pitch_angle, roll_angle, zero fill.
    output logic [((3*ANGLE_BITS+7)/8)*8-1:0]        o_m_axis_tdata
);

    localparam int E    = ELEMENT_BITS;
    localparam int A    = ANGLE_BITS;
    localparam int OW   = ((3*A+7)/8)*8;
    localparam int CW   = rm2e_pkg::CORDIC_W;
    localparam int XW   = rm2e_pkg::EXP_W;
    localparam int RW   = 2*E + 1;
    localparam int PKW  = E + 33;
    localparam int LAT  = rm2e_pkg::VEC_LATENCY;
    localparam logic [31:0] ROUND_ADD = (32'd1 << (32 - A)) >> 1;

    logic en;
    logic r_skid_valid;
    logic r_out_valid;

    // The pipeline advances while the skid register is free.
    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;

    // ---------------- Stage one: input registers ----------------
    logic                r_v1;
    logic signed [E-1:0] r_r00, r_r01, r_r02, r_r10, r_r11, r_r12, r_r20;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r00 <= i_s_axis_tdata[0*E +: E];
            r_r01 <= i_s_axis_tdata[1*E +: E];
            r_r02 <= i_s_axis_tdata[2*E +: E];
            r_r10 <= i_s_axis_tdata[3*E +: E];
            r_r11 <= i_s_axis_tdata[4*E +: E];
            r_r12 <= i_s_axis_tdata[5*E +: E];
            r_r20 <= i_s_axis_tdata[6*E +: E];
        end
    end

    // ---------------- Stage two: products ----------------
    logic                  r_v2;
    logic signed [2*E-1:0] r_pa, r_pb, r_pc, r_pd;
    logic signed [PKW-1:0] r_pk;
    logic signed [E-1:0]   r2_r00, r2_r10, r2_r11, r2_r12, r2_r20;
    logic                  r2_colzero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa       <= r_r02 * r_r10;
            r_pb       <= r_r12 * r_r00;
            r_pc       <= r_r11 * r_r00;
            r_pd       <= r_r01 * r_r10;
            r_pk       <= PKW'(-(E+1)'(r_r20)) * PKW'($signed({1'b0, rm2e_pkg::KGAIN_Q30}));
            r2_r00     <= r_r00;
            r2_r10     <= r_r10;
            r2_r11     <= r_r11;
            r2_r12     <= r_r12;
            r2_r20     <= r_r20;
            r2_colzero <= (r_r00 == '0) && (r_r10 == '0);
        end
    end

    // ---------------- Stage three: roll operands ----------------
    logic                 r_v3;
    logic signed [RW-1:0] r_rx, r_ry;
    logic signed [E-1:0]  r3_r00, r3_r10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_r00 <= r2_r00;
            r3_r10 <= r2_r10;
            if (r2_colzero) begin
                r_rx <= RW'(r2_r11);
                r_ry <= -RW'(r2_r12);
            end else begin
                r_rx <= (RW'(r_pc) >>> 1) - (RW'(r_pd) >>> 1);
                r_ry <= (RW'(r_pa) >>> 1) - (RW'(r_pb) >>> 1);
            end
        end
    end

    // ---------------- Yaw and roll CORDIC chains ----------------
    logic                 yaw_valid;
    logic        [31:0]   yaw_z;
    logic signed [CW-1:0] yaw_mag;
    logic signed [XW-1:0] yaw_expo;
    logic        [31:0]   roll_z;

    rm2e_vec_atan #(.IW(E)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v3),
        .i_x     (r3_r00),
        .i_y     (r3_r10),
        .o_valid (yaw_valid),
        .o_z     (yaw_z),
        .o_mag   (yaw_mag),
        .o_expo  (yaw_expo)
    );

    rm2e_vec_atan #(.IW(RW)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v3),
        .i_x     (r_rx),
        .i_y     (r_ry),
        .o_valid (),
        .o_z     (roll_z),
        .o_mag   (),
        .o_expo  ()
    );

    // Pitch side data waits alongside the yaw chain.
    logic [PKW+E:0] side_in, side_out;
    logic signed [PKW-1:0] d_pk;
    logic signed [E-1:0]   d_r20;
    logic                  d_colzero;

    assign side_in = {r2_colzero, r2_r20, r_pk};

    rm2e_delay #(.W(PKW+E+1), .DEPTH(LAT+1)) u_side_dly (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data (side_in),
        .o_data (side_out)
    );

    assign d_pk      = side_out[PKW-1:0];
    assign d_r20     = side_out[PKW +: E];
    assign d_colzero = side_out[PKW+E];

    // ---------------- Stage four: pitch operands ----------------
    logic                  r_v4;
    logic signed [PKW-1:0] r_px, r_py;
    logic        [XW-1:0]  pshift;

    assign pshift = XW'(30) - yaw_expo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= yaw_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (d_colzero) begin
                r_px <= '0;
                r_py <= -PKW'(d_r20);
            end else begin
                r_px <= PKW'(yaw_mag);
                r_py <= d_pk >>> pshift;
            end
        end
    end

    // ---------------- Pitch CORDIC chain ----------------
    logic        pitch_valid;
    logic [31:0] pitch_z;

    rm2e_vec_atan #(.IW(PKW)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v4),
        .i_x     (r_px),
        .i_y     (r_py),
        .o_valid (pitch_valid),
        .o_z     (pitch_z),
        .o_mag   (),
        .o_expo  ()
    );

    // Yaw and roll angles wait for pitch.
    logic [63:0] yr_out;
    logic [31:0] yaw_zero_fix;

    // A zero first column forces yaw to zero; the chain already gives zero then.
    assign yaw_zero_fix = yaw_z;

    rm2e_delay #(.W(64), .DEPTH(LAT+1)) u_yr_dly (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_data ({roll_z, yaw_zero_fix}),
        .o_data (yr_out)
    );

    // ---------------- Rounding to binary angles ----------------
    logic [31:0]   yaw_r, pitch_r, roll_r;
    logic [OW-1:0] n_data;

    always_comb begin
        yaw_r   = yr_out[31:0]  + ROUND_ADD;
        pitch_r = pitch_z       + ROUND_ADD;
        roll_r  = yr_out[63:32] + ROUND_ADD;
        n_data  = '0;
        n_data[0*A +: A] = yaw_r[31 -: A];
        n_data[1*A +: A] = pitch_r[31 -: A];
        n_data[2*A +: A] = roll_r[31 -: A];
    end

    // ---------------- Output register and skid register ----------------
    logic          push;
    logic [OW-1:0] r_out_data;
    logic [OW-1:0] r_skid_data;

    assign push = en && pitch_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_out_valid && i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            if (!r_out_valid || i_m_axis_tready) begin
                r_out_data <= n_data;
            end else begin
                r_skid_data <= n_data;
            end
        end else if (r_out_valid && i_m_axis_tready && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTH
    // The skid register only fills behind a waiting output item.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while the output register is empty");

    // An accepted item enters the first pipeline stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_v1)
        else $error("accepted item did not enter the pipeline");

    // A taken item with the skid register full leaves the skid item on the output.
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_m_axis_tready) |=> (o_m_axis_tvalid && !r_skid_valid))
        else $error("skid item lost on output transfer");
`endif

endmodule

`default_nettype wire

### sim/tb_rotation_matrix_to_euler_unit.sv
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_euler_unit
// Streams rotation matrices into the Euler angle unit and checks every
// yaw, pitch and roll item against a CORDIC predictor that runs in the bench.
// The bench drives directed corner cases first, then random rotations and
// random bit patterns. Both sides idle at random, and one long receiver
// stall fills the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rotation_matrix_to_euler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EW = 16;
    localparam int AW = 16;
    localparam int IN_W = ((7*EW+7)/8)*8;
    localparam int OUT_W = ((3*AW+7)/8)*8;
    localparam int N_RANDOM = 800;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [AW-1:0] roll;
        logic [AW-1:0] pitch;
        logic [AW-1:0] yaw;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic [IN_W-1:0] s_data = '0;
    logic m_ready = 1'b0;
    logic s_ready;
    logic m_valid;
    logic [OUT_W-1:0] m_data;

    logic [IN_W-1:0] pending_matrices[$];
    t_angles expected_angles[$];
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned matrices_accepted = 0;
    int unsigned hold_count = 0;
    bit hold_done = 1'b0;
    int unsigned error_count = 0;

    rotation_matrix_to_euler_unit #(
        .ELEMENT_BITS(EW),
        .ANGLE_BITS(AW)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Vectoring CORDIC: returns atan2(y, x) in 32-bit turns, plus the scaled
    // magnitude and the normalization exponent.
    function automatic logic [31:0] cordic_atan2(input longint x, input longint y,
                                                 output longint mag, output int expo);
        longint ax;
        longint ay;
        longint m;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        int e;
        logic [31:0] z;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m = (ax > ay) ? ax : ay;
        e = 0;
        z = '0;
        mag = 0;
        expo = 0;
        if (m == 0)
            return '0;
        while (m >= (longint'(1) << 30)) begin
            m = m >> 1;
            e--;
        end
        while (m < (longint'(1) << 29)) begin
            m = m << 1;
            e++;
        end
        if (e < 0) begin
            cx = x >>> (-e);
            cy = y >>> (-e);
        end else begin
            cx = x <<< e;
            cy = y <<< e;
        end
        // Fold the left half plane onto the right one.
        if (cx < 0) begin
            cx = -cx;
            cy = -cy;
            z = rm2e_pkg::TURN_HALF;
        end
        for (int i = 0; i < rm2e_pkg::CORDIC_STAGES; i++) begin
            dx = cx >>> i;
            dy = cy >>> i;
            if (cy < 0) begin
                cx = cx - dy;
                cy = cy + dx;
                z = z - rm2e_pkg::ATAN_TURNS[i];
            end else begin
                cx = cx + dy;
                cy = cy - dx;
                z = z + rm2e_pkg::ATAN_TURNS[i];
            end
        end
        mag = cx;
        expo = e;
        // Exact axes override the iterated angle.
        if (y == 0)
            z = (x < 0) ? rm2e_pkg::TURN_HALF : 32'd0;
        else if (x == 0)
            z = (y > 0) ? rm2e_pkg::TURN_QUARTER : rm2e_pkg::TURN_3QUARTER;
        return z;
    endfunction

    // Round a turn to the output width, halves up, wrapping at pi.
    function automatic logic [AW-1:0] turn_to_binary_angle(input logic [31:0] z);
        logic [31:0] r;
        r = (z + (32'd1 << (32-AW-1))) >> (32-AW);
        return r[AW-1:0];
    endfunction

    function automatic t_angles euler_from_matrix(input logic [IN_W-1:0] d);
        longint r00;
        longint r01;
        longint r02;
        longint r10;
        longint r11;
        longint r12;
        longint r20;
        longint hmag;
        longint dummy_mag;
        longint py;
        longint ry;
        longint rx;
        int hexp;
        int dummy_exp;
        logic [31:0] yaw;
        logic [31:0] pitch;
        logic [31:0] roll;
        t_angles a;
        r00 = longint'($signed(d[0*EW +: EW]));
        r01 = longint'($signed(d[1*EW +: EW]));
        r02 = longint'($signed(d[2*EW +: EW]));
        r10 = longint'($signed(d[3*EW +: EW]));
        r11 = longint'($signed(d[4*EW +: EW]));
        r12 = longint'($signed(d[5*EW +: EW]));
        r20 = longint'($signed(d[6*EW +: EW]));
        yaw = cordic_atan2(r00, r10, hmag, hexp);
        if (r00 == 0 && r10 == 0) begin
            // Zero first column: yaw is taken as 0.
            yaw = '0;
            pitch = cordic_atan2(0, -r20, dummy_mag, dummy_exp);
            roll = cordic_atan2(r11, -r12, dummy_mag, dummy_exp);
        end else begin
            py = (-r20 * longint'(rm2e_pkg::KGAIN_Q30)) >>> (30 - hexp);
            ry = ((r02 * r10) >>> 1) - ((r12 * r00) >>> 1);
            rx = ((r11 * r00) >>> 1) - ((r01 * r10) >>> 1);
            pitch = cordic_atan2(hmag, py, dummy_mag, dummy_exp);
            roll = cordic_atan2(rx, ry, dummy_mag, dummy_exp);
        end
        a.yaw = turn_to_binary_angle(yaw);
        a.pitch = turn_to_binary_angle(pitch);
        a.roll = turn_to_binary_angle(roll);
        return a;
    endfunction

    function automatic logic [IN_W-1:0] pack_matrix(input int r00, input int r01,
                                                    input int r02, input int r10,
                                                    input int r11, input int r12,
                                                    input int r20);
        logic [IN_W-1:0] d;
        d = '0;
        d[0*EW +: EW] = r00[EW-1:0];
        d[1*EW +: EW] = r01[EW-1:0];
        d[2*EW +: EW] = r02[EW-1:0];
        d[3*EW +: EW] = r10[EW-1:0];
        d[4*EW +: EW] = r11[EW-1:0];
        d[5*EW +: EW] = r12[EW-1:0];
        d[6*EW +: EW] = r20[EW-1:0];
        return d;
    endfunction

    // Q1.14 rotation matrix built from yaw, pitch and roll in radians.
    function automatic logic [IN_W-1:0] rotation_matrix(input real y, input real p,
                                                        input real r);
        real one;
        one = 16384.0;
        return pack_matrix(
            $rtoi($cos(y)*$cos(p)*one),
            $rtoi(($cos(y)*$sin(p)*$sin(r) - $sin(y)*$cos(r))*one),
            $rtoi(($cos(y)*$sin(p)*$cos(r) + $sin(y)*$sin(r))*one),
            $rtoi($sin(y)*$cos(p)*one),
            $rtoi(($sin(y)*$sin(p)*$sin(r) + $cos(y)*$cos(r))*one),
            $rtoi(($sin(y)*$sin(p)*$cos(r) - $cos(y)*$sin(r))*one),
            $rtoi(-$sin(p)*one));
    endfunction

    function automatic real random_angle();
        return ($urandom_range(0, 65535) / 65536.0 - 0.5) * 2.0 * 3.14159265358979;
    endfunction

    function automatic int random_element(input int lim);
        return int'($urandom_range(0, 2*lim)) - lim;
    endfunction

    // Appends one matrix item to the tail of the pending queue.
    task automatic add_matrix(input logic [IN_W-1:0] d);
        pending_matrices.insert(pending_matrices.size(), d);
    endtask

    // Sender: offers items from the pending queue with a random gap between them.
    always @(posedge i_clk) begin
        bit taken;
        taken = s_valid && s_ready;
        if (taken) begin
            expected_angles.insert(expected_angles.size(), euler_from_matrix(s_data));
            matrices_accepted <= matrices_accepted + 1;
        end
        if (i_rst_n && (!s_valid || taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_matrices.size() > 0) begin
                s_valid <= 1'b1;
                s_data <= pending_matrices.pop_front();
                send_gap <= $urandom_range(0, 3);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off so that the pipeline fills and stalls its input.
    always @(posedge i_clk) begin
        if (hold_count > 0) begin
            hold_count <= hold_count - 1;
        end else if (!hold_done && matrices_accepted >= HOLD_AT) begin
            hold_count <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Receiver: checks each result item and stalls at random between items.
    always @(posedge i_clk) begin
        t_angles got;
        t_angles want;
        if (m_valid && m_ready) begin
            got = m_data[3*AW-1:0];
            if (expected_angles.size() == 0) begin
                $error("unexpected result item %h", got);
                error_count++;
            end else begin
                want = expected_angles.pop_front();
                if (got.yaw !== want.yaw) begin
                    $error("yaw_angle: expected %0d, got %0d",
                           $signed(want.yaw), $signed(got.yaw));
                    error_count++;
                end
                if (got.pitch !== want.pitch) begin
                    $error("pitch_angle: expected %0d, got %0d",
                           $signed(want.pitch), $signed(got.pitch));
                    error_count++;
                end
                if (got.roll !== want.roll) begin
                    $error("roll_angle: expected %0d, got %0d",
                           $signed(want.roll), $signed(got.roll));
                    error_count++;
                end
            end
        end
        if (!i_rst_n || hold_count > 0) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            recv_gap = $urandom_range(0, 3);
            m_ready <= (recv_gap == 0);
        end else if (recv_gap > 0) begin
            recv_gap = recv_gap - 1;
            m_ready <= (recv_gap == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog.
    initial begin
        #(12ns * 400000);
        $display("[rotation_matrix_to_euler_unit] ERROR");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        int sel;
        // Directed corners: identity, half turns, quarter turns, zero column.
        add_matrix(pack_matrix(16384, 0, 0, 0, 16384, 0, 0));
        add_matrix(pack_matrix(-16384, 0, 0, 0, -16384, 0, 0));
        add_matrix(pack_matrix(-16384, 0, 0, -1, -16384, 0, 0));
        add_matrix(pack_matrix(0, -16384, 0, 16384, 0, 0, 0));
        add_matrix(pack_matrix(0, 16384, 0, -16384, 0, 0, 0));
        add_matrix(pack_matrix(0, 0, 0, 0, 0, 0, 0));
        add_matrix(pack_matrix(0, 0, 16384, 0, 16384, 0, -16384));
        add_matrix(pack_matrix(0, 0, -16384, 0, 0, 16384, 16384));
        add_matrix(pack_matrix(0, 0, 0, 0, -16384, 0, 0));
        add_matrix(pack_matrix(16384, 0, 0, 0, 0, -16384, 0));
        add_matrix(pack_matrix(11585, -11585, 0, 11585, 11585, 0, 0));
        // Out-of-range extremes.
        add_matrix(pack_matrix(-32768, -32768, -32768, -32768,
                               -32768, -32768, -32768));
        add_matrix(pack_matrix(32767, 32767, 32767, 32767,
                               32767, 32767, 32767));
        add_matrix(pack_matrix(-32768, 32767, -32768, 32767,
                               -32768, 32767, -32768));
        add_matrix(pack_matrix(1, 0, 0, 0, 1, 0, 1));
        add_matrix(pack_matrix(-1, 0, 0, 0, 0, 0, -32768));
        add_matrix(pack_matrix(0, 0, 0, 0, 0, 0, 32767));
        add_matrix(pack_matrix(16384, 16384, -16384, -16384,
                               16384, 16384, 16384));
        // Random part: mostly proper rotations, mixed with noise.
        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                add_matrix(rotation_matrix(random_angle(),
                                           random_angle() / 2.0, random_angle()));
            else if (sel < 75)
                add_matrix(pack_matrix(random_element(16384),
                    random_element(16384), random_element(16384), random_element(16384),
                    random_element(16384), random_element(16384), random_element(16384)));
            else if (sel < 80)
                add_matrix(pack_matrix(0, random_element(32767),
                    random_element(32767), 0, random_element(32767),
                    random_element(32767), random_element(32767)));
            else
                add_matrix(IN_W'({$urandom, $urandom, $urandom, $urandom}));
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_matrices.size() == 0 && !s_valid);
        wait (expected_angles.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_angles.size() == 0) begin
            $display("[rotation_matrix_to_euler_unit] OK");
        end else begin
            $display("[rotation_matrix_to_euler_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
src/rm2e_pkg.sv
src/rm2e_delay.sv
src/rm2e_cordic_cell.sv
src/rm2e_vec_atan.sv
src/rotation_matrix_to_euler_unit.sv
sim/tb_rotation_matrix_to_euler_unit.sv
